### sv/cbpe_pkg.sv
// Shared types and constants of the cubic Bezier point evaluator.
package cbpe_pkg;

  // Configuration register map.
  localparam int unsigned CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X    = 4'd0,
    REG_START_Y    = 4'd1,
    REG_PULL_ONE_X = 4'd2,
    REG_PULL_ONE_Y = 4'd3,
    REG_PULL_TWO_X = 4'd4,
    REG_PULL_TWO_Y = 4'd5,
    REG_END_X      = 4'd6,
    REG_END_Y      = 4'd7
  } cbpe_reg_e;

  // Pipeline layout: weight generation, then per-axis accumulation.
  localparam int unsigned BASIS_STAGES = 3;
  localparam int unsigned AXIS_STAGES  = 4;
  localparam int unsigned NUM_STAGES   = BASIS_STAGES + AXIS_STAGES;

  // Per-stage load enables from the pipeline control.
  typedef struct packed {
    logic [BASIS_STAGES-1:0] basis_en;
    logic [AXIS_STAGES-1:0]  axis_en;
  } cbpe_ctrl_t;

endpackage

### sv/cbpe_basis.sv
// Bernstein weight pipeline: clamp t, form products of t and 1-t, form cubic weights.
module cbpe_basis
  import cbpe_pkg::*;
#(
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  cbpe_ctrl_t                        ctrl_i,
  input  logic [T_FRAC_BITS:0]              t_param_i,
  output logic [3:0][3*T_FRAC_BITS:0]       weight_o
);

  localparam int unsigned T_W  = T_FRAC_BITS + 1;
  localparam int unsigned SQ_W = 2 * T_FRAC_BITS + 1;
  localparam int unsigned W_W  = 3 * T_FRAC_BITS + 1;
  localparam logic [T_W-1:0] ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  logic [T_W-1:0]    t_d, t_q, u_q;
  logic [2*T_W-1:0]  t2_full, u2_full, tu_full;
  logic [SQ_W-1:0]   t2_q, u2_q, tu_q;
  logic [T_W-1:0]    t1_q, u1_q;
  logic [SQ_W+T_W-1:0] w0_full, w1_full, w2_full, w3_full;
  logic [W_W-1:0]    w_q [4];

  // Stage 1: saturate t to 1.0, derive u = 1 - t.
  assign t_d = (t_param_i > ONE) ? ONE : t_param_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.basis_en[0]) begin
      t_q <= t_d;
      u_q <= ONE - t_d;
    end
  end

  // Stage 2: squares and cross product.
  assign t2_full = t_q * t_q;
  assign u2_full = u_q * u_q;
  assign tu_full = t_q * u_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.basis_en[1]) begin
      t2_q <= t2_full[SQ_W-1:0];
      u2_q <= u2_full[SQ_W-1:0];
      tu_q <= tu_full[SQ_W-1:0];
      t1_q <= t_q;
      u1_q <= u_q;
    end
  end

  // Stage 3: cubic weights u^3, t*u^2, t^2*u, t^3 (factor 3 sits in the coefficients).
  assign w0_full = u2_q * u1_q;
  assign w1_full = tu_q * u1_q;
  assign w2_full = tu_q * t1_q;
  assign w3_full = t2_q * t1_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.basis_en[2]) begin
      w_q[0] <= w0_full[W_W-1:0];
      w_q[1] <= w1_full[W_W-1:0];
      w_q[2] <= w2_full[W_W-1:0];
      w_q[3] <= w3_full[W_W-1:0];
    end
  end

  assign weight_o[0] = w_q[0];
  assign weight_o[1] = w_q[1];
  assign weight_o[2] = w_q[2];
  assign weight_o[3] = w_q[3];

endmodule

### sv/cbpe_axis.sv
// One coordinate axis: weighted sum of control points, rounding and saturation.
module cbpe_axis
  import cbpe_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 24,
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  cbpe_ctrl_t                    ctrl_i,
  input  logic [3:0][COORD_WIDTH-1:0]   ctrl_pt_i,
  input  logic [3:0][3*T_FRAC_BITS:0]   weight_i,
  output logic [COORD_WIDTH-1:0]        point_o
);

  localparam int unsigned W_W    = 3 * T_FRAC_BITS + 1;
  localparam int unsigned HALF   = (W_W + 1) / 2;
  localparam int unsigned HI_W   = W_W - HALF;
  localparam int unsigned CF_W   = COORD_WIDTH + 2;
  localparam int unsigned PPL_W  = CF_W + HALF + 1;
  localparam int unsigned PPH_W  = CF_W + HI_W + 1;
  localparam int unsigned SL_W   = PPL_W + 2;
  localparam int unsigned SH_W   = PPH_W + 2;
  localparam int unsigned ACC_W  = SH_W + HALF;
  localparam int unsigned SHIFT  = 3 * T_FRAC_BITS;
  localparam int unsigned RES_W  = ACC_W - SHIFT;

  localparam logic [ACC_W-1:0] ROUND_C = {{(ACC_W-1){1'b0}}, 1'b1} << (SHIFT - 1);
  localparam logic signed [RES_W-1:0] SAT_MAX =
    $signed({{(RES_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [RES_W-1:0] SAT_MIN =
    $signed({{(RES_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}});

  logic signed [CF_W-1:0]  pe [4];
  logic signed [CF_W-1:0]  coef_q [4];
  logic signed [PPL_W-1:0] pp_lo_q [4];
  logic signed [PPH_W-1:0] pp_hi_q [4];
  logic signed [SL_W-1:0]  sum_lo_q;
  logic signed [SH_W-1:0]  sum_hi_q;
  logic signed [ACC_W-1:0] acc_d, acc_q;
  logic signed [RES_W-1:0] res;
  logic [COORD_WIDTH-1:0]  point_d, point_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pe[k] = CF_W'($signed(ctrl_pt_i[k]));
    end
  end

  // Bernstein coefficients P0, 3*P1, 3*P2, P3; follow the configuration.
  always_ff @(posedge clk_i) begin
    coef_q[0] <= pe[0];
    coef_q[1] <= (pe[1] <<< 1) + pe[1];
    coef_q[2] <= (pe[2] <<< 1) + pe[2];
    coef_q[3] <= pe[3];
  end

  // Stage 4: partial products against low and high halves of each weight.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.axis_en[0]) begin
      for (int k = 0; k < 4; k++) begin
        pp_lo_q[k] <= coef_q[k] * $signed({1'b0, weight_i[k][HALF-1:0]});
        pp_hi_q[k] <= coef_q[k] * $signed({1'b0, weight_i[k][W_W-1:HALF]});
      end
    end
  end

  // Stage 5: sum each half.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.axis_en[1]) begin
      sum_lo_q <= SL_W'(pp_lo_q[0]) + SL_W'(pp_lo_q[1])
                + SL_W'(pp_lo_q[2]) + SL_W'(pp_lo_q[3]);
      sum_hi_q <= SH_W'(pp_hi_q[0]) + SH_W'(pp_hi_q[1])
                + SH_W'(pp_hi_q[2]) + SH_W'(pp_hi_q[3]);
    end
  end

  // Stage 6: recombine halves and add the rounding half LSB.
  assign acc_d = (ACC_W'(sum_hi_q) <<< HALF) + ACC_W'(sum_lo_q) + $signed(ROUND_C);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.axis_en[2]) begin
      acc_q <= acc_d;
    end
  end

  // Stage 7: drop the fraction, clamp to the coordinate range.
  assign res = $signed(acc_q[ACC_W-1:SHIFT]);

  always_comb begin
    if (res > SAT_MAX) begin
      point_d = SAT_MAX[COORD_WIDTH-1:0];
    end else if (res < SAT_MIN) begin
      point_d = SAT_MIN[COORD_WIDTH-1:0];
    end else begin
      point_d = res[COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.axis_en[3]) begin
      point_q <= point_d;
    end
  end

  assign point_o = point_q;

endmodule

### sv/cubic_bezier_point_eval.sv
// Top level of the cubic Bezier point evaluator: configuration, pipeline control, axes.
//
// Evaluates a planar cubic Bezier curve at parameter t (unsigned, T_FRAC_BITS fraction
// bits, values above 1.0 taken as 1.0) from four control points held in configuration
// registers 0..7 (start x/y, pull_one x/y, pull_two x/y, end x/y, signed 1/16 mm,
// reset 0). Each point is computed exactly in Bernstein form, rounded to nearest with
// halves toward plus infinity, and saturated to COORD_WIDTH signed bits. The block is a
// seven-stage pipeline: clamp t, products t^2/u^2/tu, cubic weights, partial products of
// the control points against split weights, partial sums, rounding add, saturation into
// the output register. It takes one transaction per cycle unless all stages are full
// and the output is stalled. Each stage holds its data while the next one is full and
// stalled, and bubbles close up, so the input keeps accepting until all seven stages are
// occupied and the output is stalled. Configuration writes are always ready and must be
// issued only while no transaction is in flight; they take effect on the next cycle.
module cubic_bezier_point_eval
  import cbpe_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 24,
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [COORD_WIDTH-1:0]  cfg_data_i,
  // parameter input
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [T_FRAC_BITS:0]    t_param_i,
  // point output
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [COORD_WIDTH-1:0]  point_x_o,
  output logic [COORD_WIDTH-1:0]  point_y_o
);

  logic [COORD_WIDTH-1:0] start_x_q, start_y_q, pull_one_x_q, pull_one_y_q;
  logic [COORD_WIDTH-1:0] pull_two_x_q, pull_two_y_q, end_x_q, end_y_q;

  logic [NUM_STAGES-1:0] v_d, v_q, ready;
  cbpe_ctrl_t            ctrl;

  logic [3:0][3*T_FRAC_BITS:0]  weight;
  logic [3:0][COORD_WIDTH-1:0]  pts_x, pts_y;

  // Configuration: always ready, decode the index, ignore writes beyond the map.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q    <= '0;
      start_y_q    <= '0;
      pull_one_x_q <= '0;
      pull_one_y_q <= '0;
      pull_two_x_q <= '0;
      pull_two_y_q <= '0;
      end_x_q      <= '0;
      end_y_q      <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cbpe_reg_e'(cfg_index_i))
        REG_START_X:    start_x_q    <= cfg_data_i;
        REG_START_Y:    start_y_q    <= cfg_data_i;
        REG_PULL_ONE_X: pull_one_x_q <= cfg_data_i;
        REG_PULL_ONE_Y: pull_one_y_q <= cfg_data_i;
        REG_PULL_TWO_X: pull_two_x_q <= cfg_data_i;
        REG_PULL_TWO_Y: pull_two_y_q <= cfg_data_i;
        REG_END_X:      end_x_q      <= cfg_data_i;
        REG_END_Y:      end_y_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage loads when it is empty or its successor moves on.
  always_comb begin
    ready[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || !out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ready[k] = !v_q[k] || ready[k+1];
    end
  end

  always_comb begin
    v_d[0] = ready[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      v_d[k] = ready[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign ctrl.basis_en = ready[BASIS_STAGES-1:0];
  assign ctrl.axis_en  = ready[NUM_STAGES-1:BASIS_STAGES];

  assign in_stall_o  = !ready[0];
  assign out_valid_o = v_q[NUM_STAGES-1];

  // Shared weight generation.
  cbpe_basis #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_basis (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .t_param_i(t_param_i),
    .weight_o (weight)
  );

  assign pts_x[0] = start_x_q;
  assign pts_x[1] = pull_one_x_q;
  assign pts_x[2] = pull_two_x_q;
  assign pts_x[3] = end_x_q;
  assign pts_y[0] = start_y_q;
  assign pts_y[1] = pull_one_y_q;
  assign pts_y[2] = pull_two_y_q;
  assign pts_y[3] = end_y_q;

  cbpe_axis #(
    .COORD_WIDTH(COORD_WIDTH),
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_axis_x (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .ctrl_pt_i(pts_x),
    .weight_i (weight),
    .point_o  (point_x_o)
  );

  cbpe_axis #(
    .COORD_WIDTH(COORD_WIDTH),
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_axis_y (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .ctrl_pt_i(pts_y),
    .weight_i (weight),
    .point_o  (point_y_o)
  );

  // An accepted transaction occupies the first stage on the next cycle.
  a_accept_fills_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v_q[0])
    else $error("accepted transaction missing from first stage");

  // The input stalls only when every stage holds a transaction.
  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("input stalled with a bubble in the pipeline");

  // A transaction in the rounding stage reaches the output when the output moves.
  a_last_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NUM_STAGES-2] && ready[NUM_STAGES-1] |=> out_valid_o)
    else $error("transaction lost before output register");

endmodule
